FILE: rtl/bwdw_pkg.sv
// ----------------------------------------------------------------------------
// Breit-Wigner shape package
// Fixed-point constants, operation codes and register indexes shared by the
// core and its arithmetic unit.
// ----------------------------------------------------------------------------
package bwdw_pkg;

	localparam int FX_W       = 64;
	localparam int MASS_SHIFT = 4;
	localparam int CFG_IDX_W  = 3;

	localparam logic [63:0] FX_ONE    = 64'd1 << 32;
	localparam logic [63:0] ALL_ONES  = {64{1'b1}};
	localparam logic [63:0] RADIUS_FX = (64'd428629 << 32) / 64'd100000;
	localparam logic [63:0] PARENT_FX = (64'd52 << 32) / 64'd10;

	// arithmetic unit operations
	localparam int OP_MUL     = 0;   // Q.32 product, saturating
	localparam int OP_MULFULL = 1;   // full 128-bit product
	localparam int OP_DIV     = 2;   // Q.32 quotient, saturating
	localparam int OP_SQRT    = 3;   // floor root of {a, b}

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESONANCE_MEAN,
		REG_NOMINAL_WIDTH,
		REG_DAUGHTER_ONE,
		REG_DAUGHTER_TWO,
		REG_SPECTATOR,
		REG_ORBITAL,
		REG_PARENT_PS
	} cfg_idx_t;

endpackage

FILE: rtl/bwdw_if.sv
// ----------------------------------------------------------------------------
// Breit-Wigner shape channels
// Valid/ready channels for mass requests, shape results and register writes.
// ----------------------------------------------------------------------------
interface bwdw_in_if #(parameter int MASS_WIDTH = 32);
	logic                  valid;
	logic                  ready;
	logic [MASS_WIDTH-1:0] candidate_mass;
	modport source (output valid, candidate_mass, input ready);
	modport sink (input valid, candidate_mass, output ready);
endinterface

interface bwdw_out_if #(parameter int OUT_WIDTH = 40);
	logic                 valid;
	logic                 ready;
	logic [OUT_WIDTH-1:0] shape_value;
	logic                 below_threshold;
	logic                 saturated;
	logic                 bad_setup;
	modport source (output valid, shape_value, below_threshold, saturated, bad_setup,
		input ready);
	modport sink (input valid, shape_value, below_threshold, saturated, bad_setup,
		output ready);
endinterface

interface bwdw_cfg_if #(parameter int MASS_WIDTH = 32);
	logic                           valid;
	logic                           ready;
	logic [bwdw_pkg::CFG_IDX_W-1:0] index;
	logic [MASS_WIDTH-1:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/breit_wigner_dependent_width_core.sv
// ----------------------------------------------------------------------------
// Breit-Wigner shape core
// Relativistic Breit-Wigner with mass-dependent width, unsigned fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   mass_in   : one candidate mass per request (Q4.28), valid/ready.
//   shape_out : one result per request: shape_value (Q24.16, saturating),
//               below_threshold, saturated, bad_setup.
//   cfg       : register writes (index, data); always ready. Write only while
//               no request is in flight.
//   A request passes through the five 65-stage divide and root chains and
//   the multipliers to the output register. Throughput is one request per
//   cycle. The whole pipeline advances on one enable: while a result waits
//   in the output register and the receiver holds ready low, every stage
//   holds and mass_in.ready is low; nothing is dropped or repeated. Reset
//   clears all valid bits and the config registers to 0; requests are taken
//   from the first cycle after reset.
// ----------------------------------------------------------------------------
module breit_wigner_dependent_width_core #(
	parameter int MASS_WIDTH = 32,
	parameter int OUT_WIDTH  = 40
) (
	input  logic     clk,
	input  logic     arst_n,
	bwdw_in_if.sink  mass_in,
	bwdw_out_if.source shape_out,
	bwdw_cfg_if.sink cfg
);

	typedef struct packed {
		logic below;
		logic bad;
	} flg_t;

	typedef struct packed {
		logic [63:0] m;
		logic        spz;
		flg_t        f;
	} sa_t;

	typedef struct packed {
		logic [63:0] m;
		logic [63:0] q;
		logic [63:0] q0;
		logic [63:0] qs;
		flg_t        f;
	} sb_t;

	typedef struct packed {
		logic [63:0] m;
		logic [63:0] qs;
		flg_t        f;
	} sc_t;

	typedef struct packed {
		logic [63:0] m;
		logic [63:0] qs;
		logic [63:0] r;
		logic [63:0] fr;
		flg_t        f;
	} sd_t;

	typedef struct packed {
		logic [63:0] m;
		logic [63:0] qs;
		logic [63:0] diff;
		flg_t        f;
	} se_t;

	typedef struct packed {
		logic [63:0] qs;
		logic [63:0] dd2;
		logic [63:0] mg;
		flg_t        f;
	} sg_t;

	typedef struct packed {
		logic [63:0] qs;
		flg_t        f;
	} sh_t;

	typedef struct packed {
		logic [63:0] bw;
		flg_t        f;
	} si_t;

	function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] z);
		logic [64:0] s;
		s = {1'b0, x} + {1'b0, z};
		return s[64] ? bwdw_pkg::ALL_ONES : s[63:0];
	endfunction

	// ------------------------------------------------------------------ config
	logic [MASS_WIDTH-1:0] mean_q, width_q, d1_q, d2_q, spec_q;
	logic                  orb_q, pps_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= '0;
			width_q <= '0;
			d1_q    <= '0;
			d2_q    <= '0;
			spec_q  <= '0;
			orb_q   <= 1'b0;
			pps_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (bwdw_pkg::cfg_idx_t'(cfg.index))
				bwdw_pkg::REG_RESONANCE_MEAN: mean_q  <= cfg.data;
				bwdw_pkg::REG_NOMINAL_WIDTH:  width_q <= cfg.data;
				bwdw_pkg::REG_DAUGHTER_ONE:   d1_q    <= cfg.data;
				bwdw_pkg::REG_DAUGHTER_TWO:   d2_q    <= cfg.data;
				bwdw_pkg::REG_SPECTATOR:      spec_q  <= cfg.data;
				bwdw_pkg::REG_ORBITAL:        orb_q   <= cfg.data[0];
				bwdw_pkg::REG_PARENT_PS:      pps_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	logic [63:0] mean_w, width_w, d1_w, d2_w, spec_w, thr, dd;

	assign mean_w  = 64'(mean_q) << bwdw_pkg::MASS_SHIFT;
	assign width_w = 64'(width_q) << bwdw_pkg::MASS_SHIFT;
	assign d1_w    = 64'(d1_q) << bwdw_pkg::MASS_SHIFT;
	assign d2_w    = 64'(d2_q) << bwdw_pkg::MASS_SHIFT;
	assign spec_w  = 64'(spec_q) << bwdw_pkg::MASS_SHIFT;
	assign thr     = d1_w + d2_w;
	assign dd      = (d1_w > d2_w) ? d1_w - d2_w : d2_w - d1_w;

	logic adv;
	logic out_vld_q;

	assign adv           = !out_vld_q || shape_out.ready;
	assign mass_in.ready = adv;

	// ------------------------------------------------------ breakup products
	logic [63:0] m_in, tsp, dsp;
	logic [63:0] a_a [6], a_b [6];
	logic [127:0] a_y [6];
	sa_t a_si, a_so;
	logic a_v;

	always_comb begin
		m_in = 64'(mass_in.candidate_mass) << bwdw_pkg::MASS_SHIFT;
		tsp  = m_in + spec_w;
		dsp  = (m_in > spec_w) ? m_in - spec_w : spec_w - m_in;
		a_a[0] = m_in - thr;                 a_b[0] = m_in + thr;
		a_a[1] = m_in - dd;                  a_b[1] = m_in + dd;
		a_a[2] = mean_w - thr;               a_b[2] = mean_w + thr;
		a_a[3] = mean_w - dd;                a_b[3] = mean_w + dd;
		a_a[4] = bwdw_pkg::PARENT_FX - tsp;  a_b[4] = bwdw_pkg::PARENT_FX + tsp;
		a_a[5] = bwdw_pkg::PARENT_FX - dsp;  a_b[5] = bwdw_pkg::PARENT_FX + dsp;
		a_si.m       = m_in;
		a_si.spz     = (bwdw_pkg::PARENT_FX <= tsp);
		a_si.f.below = (m_in <= thr);
		a_si.f.bad   = (mean_w <= thr);
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(6), .SIDE_W($bits(sa_t))) u_a (
		.clk, .arst_n, .en(adv), .in_valid(mass_in.valid), .a(a_a), .b(a_b),
		.side_in(a_si), .out_valid(a_v), .y(a_y), .side_out(a_so));

	logic [63:0] b_a [3], b_b [3];
	logic [127:0] b_y [3];
	sa_t b_so;
	logic b_v;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			b_a[i] = a_y[2*i][63:0];
			b_b[i] = a_y[2*i+1][63:0];
		end
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MULFULL), .LANES(3), .SIDE_W($bits(sa_t))) u_b (
		.clk, .arst_n, .en(adv), .in_valid(a_v), .a(b_a), .b(b_b),
		.side_in(a_so), .out_valid(b_v), .y(b_y), .side_out(b_so));

	logic [63:0] c_a [3], c_b [3];
	logic [127:0] c_y [3];
	sa_t c_so;
	logic c_v;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_a[i] = b_y[i][127:64];
			c_b[i] = b_y[i][63:0];
		end
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_SQRT), .LANES(3), .SIDE_W($bits(sa_t))) u_c (
		.clk, .arst_n, .en(adv), .in_valid(b_v), .a(c_a), .b(c_b),
		.side_in(b_so), .out_valid(c_v), .y(c_y), .side_out(c_so));

	logic [63:0] d_a [3], d_b [3];
	logic [127:0] d_y [3];
	sa_t d_so;
	logic d_v;

	always_comb begin
		for (int i = 0; i < 3; i++) d_a[i] = c_y[i][63:0];
		d_b[0] = c_so.m << 1;
		d_b[1] = mean_w << 1;
		d_b[2] = bwdw_pkg::PARENT_FX << 1;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_DIV), .LANES(3), .SIDE_W($bits(sa_t))) u_d (
		.clk, .arst_n, .en(adv), .in_valid(c_v), .a(d_a), .b(d_b),
		.side_in(c_so), .out_valid(d_v), .y(d_y), .side_out(d_so));

	// ------------------------------------------------------- barrier factor
	logic [63:0] e_a [2], e_b [2];
	logic [127:0] e_y [2];
	sb_t e_si, e_so;
	logic e_v;

	always_comb begin
		e_si.m  = d_so.m;
		e_si.q  = d_y[0][63:0];
		e_si.q0 = d_y[1][63:0];
		e_si.qs = d_so.spz ? 64'd0 : d_y[2][63:0];
		e_si.f  = d_so.f;
		e_a[0]  = e_si.q0;
		e_a[1]  = e_si.q;
		e_b[0]  = bwdw_pkg::RADIUS_FX;
		e_b[1]  = bwdw_pkg::RADIUS_FX;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(2), .SIDE_W($bits(sb_t))) u_e (
		.clk, .arst_n, .en(adv), .in_valid(d_v), .a(e_a), .b(e_b),
		.side_in(e_si), .out_valid(e_v), .y(e_y), .side_out(e_so));

	logic [63:0] f_a [2];
	logic [127:0] f_y [2];
	sb_t f_so;
	logic f_v;

	always_comb begin
		for (int i = 0; i < 2; i++) f_a[i] = e_y[i][63:0];
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(2), .SIDE_W($bits(sb_t))) u_f (
		.clk, .arst_n, .en(adv), .in_valid(e_v), .a(f_a), .b(f_a),
		.side_in(e_so), .out_valid(f_v), .y(f_y), .side_out(f_so));

	logic [63:0] g_a [2], g_b [2];
	logic [127:0] g_y [2];
	sc_t g_si, g_so;
	logic g_v;

	always_comb begin
		g_a[0]  = f_so.q;
		g_b[0]  = f_so.q0;
		g_a[1]  = sat_add(bwdw_pkg::FX_ONE, f_y[0][63:0]);
		g_b[1]  = sat_add(bwdw_pkg::FX_ONE, f_y[1][63:0]);
		g_si.m  = f_so.m;
		g_si.qs = f_so.qs;
		g_si.f  = f_so.f;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_DIV), .LANES(2), .SIDE_W($bits(sc_t))) u_g (
		.clk, .arst_n, .en(adv), .in_valid(f_v), .a(g_a), .b(g_b),
		.side_in(g_si), .out_valid(g_v), .y(g_y), .side_out(g_so));

	// ---------------------------------------------------------- width term
	logic [63:0] h_a [1];
	logic [127:0] h_y [1];
	sd_t h_si, h_so;
	logic h_v;

	always_comb begin
		h_a[0]  = g_y[0][63:0];
		h_si.m  = g_so.m;
		h_si.qs = g_so.qs;
		h_si.r  = g_y[0][63:0];
		h_si.fr = g_y[1][63:0];
		h_si.f  = g_so.f;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(1), .SIDE_W($bits(sd_t))) u_h (
		.clk, .arst_n, .en(adv), .in_valid(g_v), .a(h_a), .b(h_a),
		.side_in(h_si), .out_valid(h_v), .y(h_y), .side_out(h_so));

	logic [63:0] i_a [1], i_b [1];
	logic [127:0] i_y [1];
	sd_t i_so;
	logic i_v;

	always_comb begin
		i_a[0] = h_y[0][63:0];
		i_b[0] = h_so.r;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(1), .SIDE_W($bits(sd_t))) u_i (
		.clk, .arst_n, .en(adv), .in_valid(h_v), .a(i_a), .b(i_b),
		.side_in(h_so), .out_valid(i_v), .y(i_y), .side_out(i_so));

	logic [63:0] j_a [1], j_b [1];
	logic [127:0] j_y [1];
	sd_t j_so;
	logic j_v;

	always_comb begin
		j_a[0] = i_y[0][63:0];
		j_b[0] = i_so.fr;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(1), .SIDE_W($bits(sd_t))) u_j (
		.clk, .arst_n, .en(adv), .in_valid(i_v), .a(j_a), .b(j_b),
		.side_in(i_so), .out_valid(j_v), .y(j_y), .side_out(j_so));

	logic [63:0] k_a [1], k_b [1];
	logic [127:0] k_y [1];
	sc_t k_si, k_so;
	logic k_v;

	always_comb begin
		k_a[0]  = orb_q ? j_y[0][63:0] : j_so.r;
		k_b[0]  = width_w;
		k_si.m  = j_so.m;
		k_si.qs = j_so.qs;
		k_si.f  = j_so.f;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(1), .SIDE_W($bits(sc_t))) u_k (
		.clk, .arst_n, .en(adv), .in_valid(j_v), .a(k_a), .b(k_b),
		.side_in(k_si), .out_valid(k_v), .y(k_y), .side_out(k_so));

	logic [63:0] l_a [3], l_b [3];
	logic [127:0] l_y [3];
	sc_t l_so;
	logic l_v;

	always_comb begin
		l_a[0] = k_y[0][63:0];  l_b[0] = mean_w;
		l_a[1] = k_so.m;        l_b[1] = k_so.m;
		l_a[2] = mean_w;        l_b[2] = mean_w;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(3), .SIDE_W($bits(sc_t))) u_l (
		.clk, .arst_n, .en(adv), .in_valid(k_v), .a(l_a), .b(l_b),
		.side_in(k_so), .out_valid(l_v), .y(l_y), .side_out(l_so));

	logic [63:0] m_a [1], m_b [1];
	logic [127:0] m_y [1];
	se_t m_si, m_so;
	logic m_v;

	always_comb begin
		m_a[0]    = l_y[0][63:0];
		m_b[0]    = l_so.m;
		m_si.m    = l_so.m;
		m_si.qs   = l_so.qs;
		m_si.diff = (l_y[1][63:0] > l_y[2][63:0]) ? l_y[1][63:0] - l_y[2][63:0]
			: l_y[2][63:0] - l_y[1][63:0];
		m_si.f    = l_so.f;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_DIV), .LANES(1), .SIDE_W($bits(se_t))) u_m (
		.clk, .arst_n, .en(adv), .in_valid(l_v), .a(m_a), .b(m_b),
		.side_in(m_si), .out_valid(m_v), .y(m_y), .side_out(m_so));

	// --------------------------------------------------------- denominator
	logic [63:0] n_a [3], n_b [3];
	logic [127:0] n_y [3];
	sh_t n_si, n_so;
	logic n_v;

	always_comb begin
		n_a[0]  = m_so.diff;     n_b[0] = m_so.diff;
		n_a[1]  = m_y[0][63:0];  n_b[1] = m_y[0][63:0];
		n_a[2]  = m_so.m;        n_b[2] = m_y[0][63:0];
		n_si.qs = m_so.qs;
		n_si.f  = m_so.f;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(3), .SIDE_W($bits(sh_t))) u_n (
		.clk, .arst_n, .en(adv), .in_valid(m_v), .a(n_a), .b(n_b),
		.side_in(n_si), .out_valid(n_v), .y(n_y), .side_out(n_so));

	logic [63:0] o_a [1], o_b [1];
	logic [127:0] o_y [1];
	sg_t o_si, o_so;
	logic o_v;

	always_comb begin
		o_a[0]   = n_y[1][63:0];
		o_b[0]   = mean_w;
		o_si.qs  = n_so.qs;
		o_si.dd2 = n_y[0][63:0];
		o_si.mg  = n_y[2][63:0];
		o_si.f   = n_so.f;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(1), .SIDE_W($bits(sg_t))) u_o (
		.clk, .arst_n, .en(adv), .in_valid(n_v), .a(o_a), .b(o_b),
		.side_in(o_si), .out_valid(o_v), .y(o_y), .side_out(o_so));

	logic [63:0] p_a [1], p_b [1];
	logic [127:0] p_y [1];
	sg_t p_so;
	logic p_v;

	always_comb begin
		p_a[0] = o_y[0][63:0];
		p_b[0] = mean_w;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(1), .SIDE_W($bits(sg_t))) u_p (
		.clk, .arst_n, .en(adv), .in_valid(o_v), .a(p_a), .b(p_b),
		.side_in(o_so), .out_valid(p_v), .y(p_y), .side_out(p_so));

	logic [63:0] q_a [1], q_b [1];
	logic [127:0] q_y [1];
	sh_t q_si, q_so;
	logic q_v;

	always_comb begin
		q_a[0]  = p_so.mg;
		q_b[0]  = sat_add(p_so.dd2, p_y[0][63:0]);
		q_si.qs = p_so.qs;
		q_si.f  = p_so.f;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_DIV), .LANES(1), .SIDE_W($bits(sh_t))) u_q (
		.clk, .arst_n, .en(adv), .in_valid(p_v), .a(q_a), .b(q_b),
		.side_in(q_si), .out_valid(q_v), .y(q_y), .side_out(q_so));

	// ------------------------------------------------ spectator and output
	logic [63:0] r_a [1], r_b [1];
	logic [127:0] r_y [1];
	si_t r_si, r_so;
	logic r_v;

	always_comb begin
		r_a[0]  = q_y[0][63:0];
		r_b[0]  = q_so.qs;
		r_si.bw = q_y[0][63:0];
		r_si.f  = q_so.f;
	end

	bwdw_fxop #(.OP(bwdw_pkg::OP_MUL), .LANES(1), .SIDE_W($bits(si_t))) u_r (
		.clk, .arst_n, .en(adv), .in_valid(q_v), .a(r_a), .b(r_b),
		.side_in(r_si), .out_valid(r_v), .y(r_y), .side_out(r_so));

	logic [63:0]          bwf, v64;
	logic                 clip, zero;
	logic [OUT_WIDTH-1:0] value_q;
	logic                 below_q, sat_q, bad_q;

	always_comb begin
		bwf  = pps_q ? r_y[0][63:0] : r_so.bw;
		v64  = {16'd0, bwf[63:16]};
		clip = (v64 >> OUT_WIDTH) != 64'd0;
		zero = r_so.f.below || r_so.f.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_vld_q <= 1'b0;
		else if (adv) out_vld_q <= r_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero) value_q <= '0;
			else if (clip) value_q <= '1;
			else value_q <= v64[OUT_WIDTH-1:0];
			sat_q   <= !zero && clip;
			below_q <= r_so.f.below;
			bad_q   <= r_so.f.bad;
		end
	end

	assign shape_out.valid           = out_vld_q;
	assign shape_out.shape_value     = value_q;
	assign shape_out.below_threshold = below_q;
	assign shape_out.saturated       = sat_q;
	assign shape_out.bad_setup       = bad_q;

endmodule

FILE: rtl/bwdw_fxop.sv
// ----------------------------------------------------------------------------
// Breit-Wigner pipelined arithmetic unit
// LANES parallel Q.32 operations of one kind (multiply, full multiply, divide,
// square root), fully pipelined, with a sideband word that rides along.
// ----------------------------------------------------------------------------
module bwdw_fxop #(
	parameter int OP     = 0,
	parameter int LANES  = 1,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [63:0]       a [LANES],
	input  logic [63:0]       b [LANES],
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_valid,
	output logic [127:0]      y [LANES],
	output logic [SIDE_W-1:0] side_out
);

	localparam int STEPS = 64;
	localparam int LAT   = (OP == bwdw_pkg::OP_MUL || OP == bwdw_pkg::OP_MULFULL) ? 3 : STEPS + 1;

	logic              vld_q  [LAT];
	logic [SIDE_W-1:0] side_q [LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int k = 1; k < LAT; k++) side_q[k] <= side_q[k-1];
		end
	end

	assign out_valid = vld_q[LAT-1];
	assign side_out  = side_q[LAT-1];

	if (OP == bwdw_pkg::OP_MUL || OP == bwdw_pkg::OP_MULFULL) begin : g_mul
		logic [63:0]  a_s0 [LANES];
		logic [63:0]  b_s0 [LANES];
		logic [63:0]  p00_s1 [LANES];
		logic [63:0]  p01_s1 [LANES];
		logic [63:0]  p10_s1 [LANES];
		logic [63:0]  p11_s1 [LANES];
		logic [127:0] full [LANES];
		logic [127:0] res [LANES];
		logic [127:0] y_s2 [LANES];

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				full[l] = {64'd0, p00_s1[l]} + {32'd0, p01_s1[l], 32'd0}
					+ {32'd0, p10_s1[l], 32'd0} + {p11_s1[l], 64'd0};
				if (OP == bwdw_pkg::OP_MULFULL) res[l] = full[l];
				else if (|full[l][127:96]) res[l] = {64'd0, bwdw_pkg::ALL_ONES};
				else res[l] = {64'd0, full[l][95:32]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					a_s0[l]   <= a[l];
					b_s0[l]   <= b[l];
					p00_s1[l] <= 64'(a_s0[l][31:0]) * 64'(b_s0[l][31:0]);
					p01_s1[l] <= 64'(a_s0[l][31:0]) * 64'(b_s0[l][63:32]);
					p10_s1[l] <= 64'(a_s0[l][63:32]) * 64'(b_s0[l][31:0]);
					p11_s1[l] <= 64'(a_s0[l][63:32]) * 64'(b_s0[l][63:32]);
					y_s2[l]   <= res[l];
				end
			end
		end

		assign y = y_s2;
	end else if (OP == bwdw_pkg::OP_DIV) begin : g_div
		typedef struct packed {
			logic dz;
			logic ovf;
			logic nz;
		} dflg_t;

		logic [63:0]  rem_q [STEPS][LANES];
		logic [63:0]  quo_q [STEPS][LANES];
		logic [63:0]  lo_q  [STEPS][LANES];
		logic [63:0]  den_q [STEPS][LANES];
		dflg_t        flg_q [STEPS][LANES];
		logic [63:0]  rem_n [STEPS][LANES];
		logic [63:0]  quo_n [STEPS][LANES];
		logic [63:0]  lo_n  [STEPS][LANES];
		logic [127:0] y_s   [LANES];

		// restoring division, one quotient bit per stage
		always_comb begin
			logic [63:0] r2;
			logic        ge;
			for (int k = 0; k < STEPS; k++) begin
				for (int l = 0; l < LANES; l++) begin
					r2 = {rem_q[k][l][62:0], lo_q[k][l][63]};
					ge = rem_q[k][l][63] | (r2 >= den_q[k][l]);
					rem_n[k][l] = ge ? r2 - den_q[k][l] : r2;
					quo_n[k][l] = {quo_q[k][l][62:0], ge};
					lo_n[k][l]  = {lo_q[k][l][62:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					rem_q[0][l] <= {32'd0, a[l][63:32]};
					lo_q[0][l]  <= {a[l][31:0], 32'd0};
					den_q[0][l] <= b[l];
					quo_q[0][l] <= 64'd0;
					flg_q[0][l] <= '{dz: (b[l] == 64'd0), ovf: ({32'd0, a[l][63:32]} >= b[l]),
						nz: (a[l] != 64'd0)};
					for (int k = 1; k < STEPS; k++) begin
						rem_q[k][l] <= rem_n[k-1][l];
						quo_q[k][l] <= quo_n[k-1][l];
						lo_q[k][l]  <= lo_n[k-1][l];
						den_q[k][l] <= den_q[k-1][l];
						flg_q[k][l] <= flg_q[k-1][l];
					end
					if (flg_q[STEPS-1][l].dz)
						y_s[l] <= {64'd0, flg_q[STEPS-1][l].nz ? bwdw_pkg::ALL_ONES : 64'd0};
					else if (flg_q[STEPS-1][l].ovf)
						y_s[l] <= {64'd0, bwdw_pkg::ALL_ONES};
					else
						y_s[l] <= {64'd0, quo_n[STEPS-1][l]};
				end
			end
		end

		assign y = y_s;
	end else begin : g_sqrt
		logic [127:0] x_q    [STEPS][LANES];
		logic [65:0]  rem_q  [STEPS][LANES];
		logic [63:0]  root_q [STEPS][LANES];
		logic [127:0] x_n    [STEPS][LANES];
		logic [65:0]  rem_n  [STEPS][LANES];
		logic [63:0]  root_n [STEPS][LANES];
		logic [127:0] y_s    [LANES];

		// digit-by-digit root, one bit per stage
		always_comb begin
			logic [67:0] r2;
			logic [67:0] trial;
			logic [67:0] diff;
			logic        ge;
			for (int k = 0; k < STEPS; k++) begin
				for (int l = 0; l < LANES; l++) begin
					r2    = {rem_q[k][l], x_q[k][l][127:126]};
					trial = {2'b00, root_q[k][l], 2'b01};
					diff  = r2 - trial;
					ge    = (r2 >= trial);
					rem_n[k][l]  = ge ? diff[65:0] : r2[65:0];
					root_n[k][l] = {root_q[k][l][62:0], ge};
					x_n[k][l]    = {x_q[k][l][125:0], 2'b00};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < LANES; l++) begin
					x_q[0][l]    <= {a[l], b[l]};
					rem_q[0][l]  <= 66'd0;
					root_q[0][l] <= 64'd0;
					for (int k = 1; k < STEPS; k++) begin
						x_q[k][l]    <= x_n[k-1][l];
						rem_q[k][l]  <= rem_n[k-1][l];
						root_q[k][l] <= root_n[k-1][l];
					end
					y_s[l] <= {64'd0, root_n[STEPS-1][l]};
				end
			end
		end

		assign y = y_s;
	end

endmodule

FILE: rtl/bwdw_checker.sv
// ----------------------------------------------------------------------------
// Breit-Wigner shape port checker
// Port-level properties of the request and result channels, bound to the core.
// ----------------------------------------------------------------------------
module bwdw_checker #(
	parameter int OUT_WIDTH = 40
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [OUT_WIDTH-1:0] shape_value,
	input logic                 below_threshold,
	input logic                 saturated,
	input logic                 bad_setup
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("request blocked with empty output");

	a_below_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && below_threshold |-> shape_value == '0 && !saturated)
		else $error("nonzero value below threshold");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_setup |-> shape_value == '0 && !saturated)
		else $error("nonzero value with bad setup");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> &shape_value)
		else $error("saturated value not at maximum");

endmodule

bind breit_wigner_dependent_width_core bwdw_checker #(.OUT_WIDTH(OUT_WIDTH)) u_bwdw_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (mass_in.ready),
	.out_valid       (shape_out.valid),
	.out_ready       (shape_out.ready),
	.shape_value     (shape_out.shape_value),
	.below_threshold (shape_out.below_threshold),
	.saturated       (shape_out.saturated),
	.bad_setup       (shape_out.bad_setup)
);

FILE: tb/sv/breit_wigner_dependent_width_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Breit-Wigner shape core test
// Drives candidate masses through the valid/ready request channel under several
// register setups (zero, physical, wide, all-ones, mean on threshold) and
// checks every result field against a fixed-point shape predictor, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module breit_wigner_dependent_width_core_test;

	localparam int MW = 32;
	localparam int OW = 40;
	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic [OW-1:0] value;
		logic          below;
		logic          sat;
		logic          bad;
	} shape_t;

	logic clk;
	logic arst_n;

	bwdw_in_if #(.MASS_WIDTH(MW)) mass_in();
	bwdw_out_if #(.OUT_WIDTH(OW)) shape_out();
	bwdw_cfg_if #(.MASS_WIDTH(MW)) cfg();

	breit_wigner_dependent_width_core #(.MASS_WIDTH(MW), .OUT_WIDTH(OW)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.mass_in(mass_in),
		.shape_out(shape_out),
		.cfg(cfg)
	);

	// register copy
	logic [MW-1:0] r_mean, r_width, r_d1, r_d2, r_spec;
	logic          r_l, r_bps;

	logic [MW-1:0] mass_queue[$];
	shape_t        shape_expected[$];
	int            errors = 0;
	int            requests = 0;
	int            results = 0;
	int            saturations = 0;
	int            belows = 0;
	bit            mass_taken = 0;
	bit            shape_taken = 0;
	int            idle_cycles = 0;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		if (p[127:96] != 32'd0)
			return bwdw_pkg::ALL_ONES;
		return p[95:32];
	endfunction

	function automatic logic [63:0] wide_quot(logic [127:0] n, logic [63:0] d);
		logic [127:0] q;
		if (d == 64'd0)
			return (n != 128'd0) ? bwdw_pkg::ALL_ONES : 64'd0;
		if (n[127:64] >= d)
			return bwdw_pkg::ALL_ONES;
		q = n / {64'd0, d};
		return q[63:0];
	endfunction

	function automatic logic [63:0] fx_div(logic [63:0] a, logic [63:0] b);
		return wide_quot({64'd0, a} << 32, b);
	endfunction

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? bwdw_pkg::ALL_ONES : s[63:0];
	endfunction

	function automatic logic [63:0] floor_root(logic [127:0] x);
		logic [63:0] r, c;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			c = r | (64'd1 << i);
			if ({64'd0, c} * {64'd0, c} <= x)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] momentum(logic [63:0] p, logic [63:0] x, logic [63:0] y);
		logic [63:0] t, d, u, v, s;
		t = x + y;
		d = (x > y) ? x - y : y - x;
		if (p <= t)
			return 64'd0;
		u = fx_mul(p - t, p + t);
		v = fx_mul(p - d, p + d);
		s = floor_root({64'd0, u} * {64'd0, v});
		return fx_div(s, p << 1);
	endfunction

	function automatic shape_t predict_shape(logic [MW-1:0] cand);
		shape_t o;
		logic [63:0] m, mean, g0, d1, d2, spec, thr;
		logic [63:0] q, q0, r, term, a, b, f, g, m2, mean2, diff, den, bw, v;
		m = {32'd0, cand} << bwdw_pkg::MASS_SHIFT;
		mean = {32'd0, r_mean} << bwdw_pkg::MASS_SHIFT;
		g0 = {32'd0, r_width} << bwdw_pkg::MASS_SHIFT;
		d1 = {32'd0, r_d1} << bwdw_pkg::MASS_SHIFT;
		d2 = {32'd0, r_d2} << bwdw_pkg::MASS_SHIFT;
		spec = {32'd0, r_spec} << bwdw_pkg::MASS_SHIFT;
		thr = d1 + d2;
		o.below = (m <= thr);
		o.bad = (mean <= thr);
		o.value = '0;
		o.sat = 1'b0;
		if (!o.below && !o.bad) begin
			q = momentum(m, d1, d2);
			q0 = momentum(mean, d1, d2);
			r = fx_div(q, q0);
			term = r;
			if (r_l) begin
				a = fx_mul(q0, bwdw_pkg::RADIUS_FX);
				b = fx_mul(q, bwdw_pkg::RADIUS_FX);
				f = fx_div(sat_sum(bwdw_pkg::FX_ONE, fx_mul(a, a)),
					sat_sum(bwdw_pkg::FX_ONE, fx_mul(b, b)));
				term = fx_mul(fx_mul(fx_mul(r, r), r), f);
			end
			g = fx_div(fx_mul(fx_mul(term, g0), mean), m);
			m2 = fx_mul(m, m);
			mean2 = fx_mul(mean, mean);
			diff = (m2 > mean2) ? m2 - mean2 : mean2 - m2;
			den = sat_sum(fx_mul(diff, diff), fx_mul(fx_mul(fx_mul(g, g), mean), mean));
			bw = fx_div(fx_mul(m, g), den);
			if (r_bps)
				bw = fx_mul(bw, momentum(bwdw_pkg::PARENT_FX, m, spec));
			v = bw >> 16;
			if (v > {{(64-OW){1'b0}}, {OW{1'b1}}}) begin
				o.value = {OW{1'b1}};
				o.sat = 1'b1;
			end else begin
				o.value = v[OW-1:0];
			end
		end
		return o;
	endfunction

	// request driver
	bit mass_busy = 0;
	int mass_gap = 0;
	bit mass_burst = 0;
	always @(negedge clk) begin
		bit nv;
		if (!arst_n) begin
			mass_in.valid <= 1'b0;
			mass_in.candidate_mass <= '0;
		end else begin
			nv = mass_in.valid;
			if (mass_busy && mass_taken) begin
				nv = 1'b0;
				mass_busy = 0;
				if ($urandom_range(0, 40) == 0)
					mass_burst = ~mass_burst;
				mass_gap = mass_burst ? 0 : int'($urandom_range(0, 16));
			end
			if (!mass_busy) begin
				if (mass_gap > 0) begin
					mass_gap--;
				end else if (mass_queue.size() > 0) begin
					mass_in.candidate_mass <= mass_queue.pop_front();
					nv = 1'b1;
					mass_busy = 1;
				end
			end
			mass_in.valid <= nv;
		end
	end

	// result receiver
	int shape_wait = 0;
	always @(negedge clk) begin
		if (shape_taken)
			shape_wait = mass_burst ? 0 : int'($urandom_range(0, 16));
		if (shape_wait > 0) begin
			shape_wait--;
			shape_out.ready <= 1'b0;
		end else begin
			shape_out.ready <= arst_n;
		end
	end

	// monitor
	always @(posedge clk) begin
		shape_t e;
		mass_taken = mass_in.valid && mass_in.ready;
		shape_taken = shape_out.valid && shape_out.ready;
		if (mass_taken) begin
			shape_expected.push_back(predict_shape(mass_in.candidate_mass));
			requests++;
		end
		if (shape_taken) begin
			results++;
			if (shape_expected.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				e = shape_expected.pop_front();
				if (shape_out.shape_value !== e.value) begin
					$error("shape_value exp %h got %h", e.value, shape_out.shape_value);
					errors++;
				end
				if (shape_out.below_threshold !== e.below) begin
					$error("below_threshold exp %b got %b", e.below, shape_out.below_threshold);
					errors++;
				end
				if (shape_out.saturated !== e.sat) begin
					$error("saturated exp %b got %b", e.sat, shape_out.saturated);
					errors++;
				end
				if (shape_out.bad_setup !== e.bad) begin
					$error("bad_setup exp %b got %b", e.bad, shape_out.bad_setup);
					errors++;
				end
				saturations += int'(e.sat);
				belows += int'(e.below);
			end
		end
		if (mass_taken || shape_taken ||
				(mass_queue.size() == 0 && !mass_busy && shape_expected.size() == 0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("stalled with %0d results outstanding", shape_expected.size());
			$display("breit_wigner_dependent_width_core_test: errors");
			$finish;
		end
	end

	task automatic write_reg(bwdw_pkg::cfg_idx_t idx, logic [MW-1:0] d);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			bwdw_pkg::REG_RESONANCE_MEAN: r_mean = d;
			bwdw_pkg::REG_NOMINAL_WIDTH:  r_width = d;
			bwdw_pkg::REG_DAUGHTER_ONE:   r_d1 = d;
			bwdw_pkg::REG_DAUGHTER_TWO:   r_d2 = d;
			bwdw_pkg::REG_SPECTATOR:      r_spec = d;
			bwdw_pkg::REG_ORBITAL:        r_l = d[0];
			bwdw_pkg::REG_PARENT_PS:      r_bps = d[0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic setup(logic [MW-1:0] mean, logic [MW-1:0] width, logic [MW-1:0] d1,
			logic [MW-1:0] d2, logic [MW-1:0] spec, logic [MW-1:0] l, logic [MW-1:0] bps);
		write_reg(bwdw_pkg::REG_RESONANCE_MEAN, mean);
		write_reg(bwdw_pkg::REG_NOMINAL_WIDTH, width);
		write_reg(bwdw_pkg::REG_DAUGHTER_ONE, d1);
		write_reg(bwdw_pkg::REG_DAUGHTER_TWO, d2);
		write_reg(bwdw_pkg::REG_SPECTATOR, spec);
		write_reg(bwdw_pkg::REG_ORBITAL, l);
		write_reg(bwdw_pkg::REG_PARENT_PS, bps);
	endtask

	task automatic wait_idle();
		wait (mass_queue.size() == 0 && !mass_busy && shape_expected.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [MW-1:0] q428(real x);
		return MW'($rtoi(x * 268435456.0));
	endfunction

	// mostly masses near the resonance, some near threshold, some anywhere
	task automatic queue_random(int n);
		logic [33:0] thr, span, v;
		for (int i = 0; i < n; i++) begin
			thr = 34'(r_d1) + 34'(r_d2);
			span = (34'(r_mean) > thr) ? 34'((34'(r_mean) - thr) << 1) + 34'd1
				: 34'd1 << 28;
			case ($urandom_range(0, 19))
				0, 1, 2: v = 34'($urandom);
				3, 4, 5: v = thr + 34'($urandom_range(0, 2000)) - 34'd1000;
				default: v = thr + 34'd1 + 34'({$urandom, $urandom} % {30'd0, span});
			endcase
			mass_queue.push_back(v[33:32] != 2'd0 ? {MW{1'b1}} : v[MW-1:0]);
		end
	endtask

	task automatic queue_edges();
		logic [MW-1:0] thr;
		thr = r_d1 + r_d2;
		mass_queue.push_back('0);
		mass_queue.push_back({MW{1'b1}});
		mass_queue.push_back(32'h8000_0000);
		mass_queue.push_back(32'h5555_5555);
		mass_queue.push_back(32'hAAAA_AAAA);
		mass_queue.push_back(thr);
		mass_queue.push_back(thr + 32'd1);
		mass_queue.push_back(thr - 32'd1);
		mass_queue.push_back(r_mean);
		mass_queue.push_back(r_mean + 32'd1);
		mass_queue.push_back(r_mean - 32'd1);
		mass_queue.push_back(q428(5.2) - r_spec);
		mass_queue.push_back(q428(5.2) - r_spec - 32'd1);
	endtask

	initial begin
		arst_n = 0;
		cfg.valid = 0;
		cfg.index = bwdw_pkg::REG_RESONANCE_MEAN;
		cfg.data = 0;
		r_mean = 0; r_width = 0; r_d1 = 0; r_d2 = 0; r_spec = 0; r_l = 0; r_bps = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset setup: mean on threshold
		queue_edges();
		wait_idle();

		setup(q428(0.775), q428(0.149), q428(0.13957), q428(0.13957), q428(0.49368), 1, 1);
		queue_edges();
		queue_random(280);
		wait_idle();

		setup(q428(0.89166), q428(0.0508), q428(0.13957), q428(0.49368), q428(1.86), 0, 0);
		queue_random(200);
		wait_idle();

		setup(q428(3.097), 1, q428(1.2), q428(0.1), q428(4.0), 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		queue_random(120);
		wait_idle();

		// widest range: zero daughters, maximal mean and width
		setup({MW{1'b1}}, {MW{1'b1}}, 0, 0, 0, 1, 1);
		queue_edges();
		queue_random(130);
		wait_idle();

		setup(q428(1.0), 0, q428(0.25), q428(0.25), {MW{1'b1}}, 0, 1);
		queue_random(60);
		wait_idle();

		// daughters at maximum: every mass below threshold
		setup({MW{1'b1}}, {MW{1'b1}}, {MW{1'b1}}, {MW{1'b1}}, {MW{1'b1}}, 1, 0);
		queue_random(40);
		wait_idle();

		// mean one LSB above threshold
		setup(q428(0.5), q428(0.1), q428(0.2), q428(0.3), q428(0.3), 0, 0);
		queue_random(60);
		wait_idle();

		setup(q428(1.5), q428(0.6), q428(0.0005), q428(0.0005), 0, 1, 0);
		queue_random(60);
		wait_idle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests over nine register setups, %0d results checked", requests,
			results);
		$display("%0d below threshold, %0d saturated", belows, saturations);
		if (errors == 0 && shape_expected.size() == 0) begin
			$display("breit_wigner_dependent_width_core_test: clean");
		end else begin
			$display("breit_wigner_dependent_width_core_test: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/bwdw_pkg.sv
rtl/bwdw_if.sv
rtl/bwdw_fxop.sv
rtl/breit_wigner_dependent_width_core.sv
rtl/bwdw_checker.sv
tb/sv/breit_wigner_dependent_width_core_test.sv
